// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/hhtu_pkg.sv =====
package hhtu_pkg;

  localparam int unsigned TABLE_SIZE = 1024;  // power of two
  localparam int unsigned AW         = $clog2(TABLE_SIZE);
  localparam int unsigned NBH        = 32;    // neighborhood, hop bitmap width
  localparam int unsigned OW         = $clog2(NBH);

  localparam logic [63:0] MM_MUL    = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MM_SEED   = 64'd123;
  localparam int unsigned MM_SHIFT  = 47;
  // seed ^ (len * mul) with len = 4 bytes
  localparam logic [63:0] HASH_INIT = MM_SEED ^ (MM_MUL << 2);

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_ABSENT = 2'd1;
  localparam logic [1:0] STS_DUP    = 2'd2;
  localparam logic [1:0] STS_FULL   = 2'd3;

  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [31:0] value;
  } slot_t;

endpackage

// ===== rtl/hopscotch_hash_table_unit.sv =====
// Hopscotch hash table, 1024 slots of 32-bit key / 32-bit value, 32-slot
// neighborhoods. Issue a lookup, insert or delete transaction by raising start_i
// while busy_o is low; exactly one status comes back later on status_o, marked
// by a one-cycle done_o strobe. The receiver cannot stall: sample status_o
// whenever done_o is high. A new transaction may be issued in the strobe cycle.
// After reset the block runs a clearing pass over the slot and hop memories
// with busy_o high. The MurmurHash64A home bucket is computed on one shared
// 32x32 multiplier (three partial products per 64-bit multiply), then the hop
// bitmap is read, then one slot read per neighborhood offset until a hit or the
// end of the neighborhood. An insert adds a linear free-slot probe (one slot
// per cycle, up to 1024), distance checks of the hole and, per displacement,
// one slot read per candidate, a rehash of each used candidate and a move of
// the chosen one; a final slot and hop-bitmap write ends the insert.
// Type 3 answers "not present" next cycle.
`include "assert_macros.svh"

module hopscotch_hash_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] req_key_i,
  input  logic [31:0] req_value_i,
  output logic        done_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW  = hhtu_pkg::AW;
  localparam int unsigned OW  = hhtu_pkg::OW;
  localparam int unsigned NBH = hhtu_pkg::NBH;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HOPRD = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_PROBE = 4'd5;
  localparam logic [3:0] S_DCHK  = 4'd6;
  localparam logic [3:0] S_CRD   = 4'd7;
  localparam logic [3:0] S_CHASH = 4'd8;
  localparam logic [3:0] S_MV1   = 4'd9;
  localparam logic [3:0] S_MV2   = 4'd10;
  localparam logic [3:0] S_FWR   = 4'd11;

  // ---------------- memories ----------------
  hhtu_pkg::slot_t slot_mem [hhtu_pkg::TABLE_SIZE];
  logic [NBH-1:0]  hop_mem  [hhtu_pkg::TABLE_SIZE];

  logic            slot_we, hop_we;
  logic [AW-1:0]   slot_waddr, slot_raddr, hop_waddr, hop_raddr;
  hhtu_pkg::slot_t slot_wdata, slot_rdata_q;
  logic [NBH-1:0]  hop_wdata, hop_rdata_q;

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hop_we) begin
      hop_mem[hop_waddr] <= hop_wdata;
    end
    hop_rdata_q <= hop_mem[hop_raddr];
  end

  // ---------------- hash unit ----------------
  // steps 0-2: first 64-bit multiply, 3: xor-shift, 4-6: second multiply,
  // 7: result valid (final xor-shift is combinational, only low bits used)
  logic        hrun_q;
  logic [2:0]  hstep_q;
  logic [63:0] hx_q, acc_q, mixed, prod;
  logic [31:0] mul_a, mul_b;
  logic        hash_go, hash_done;
  logic [31:0] hash_key;
  logic [AW-1:0] hash_home;

  always_comb begin
    mul_a     = (hstep_q[1:0] == 2'd1) ? hx_q[63:32] : hx_q[31:0];
    mul_b     = (hstep_q[1:0] == 2'd2) ? hhtu_pkg::MM_MUL[63:32] : hhtu_pkg::MM_MUL[31:0];
    prod      = mul_a * mul_b;
    mixed     = acc_q ^ (acc_q >> hhtu_pkg::MM_SHIFT);
    hash_done = hrun_q && (hstep_q == 3'd7);
    hash_home = mixed[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hrun_q  <= 1'b0;
      hstep_q <= '0;
    end else if (hash_go) begin
      hrun_q  <= 1'b1;
      hstep_q <= '0;
    end else if (hrun_q) begin
      hstep_q <= hstep_q + 3'd1;
      if (hstep_q == 3'd7) begin
        hrun_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hash_go) begin
      hx_q <= hhtu_pkg::HASH_INIT ^ {32'd0, hash_key};
    end else if (hrun_q) begin
      case (hstep_q[1:0])
        2'd0:    acc_q <= prod;
        2'd3:    hx_q <= mixed;
        default: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      endcase
    end
  end

  // ---------------- control ----------------
  logic [3:0]    state_q, state_d;
  logic [AW-1:0] off_q, off_d;        // scan offset, also clear counter
  logic          done_q, done_d;
  logic [1:0]    status_q, status_d;
  logic [1:0]    type_q, type_d;
  logic [31:0]   key_q, key_d, val_q, val_d;
  logic [31:0]   ckey_q, ckey_d, cval_q, cval_d;
  logic [AW-1:0] home_q, home_d, free_q, free_d, ch_q, ch_d;
  logic [NBH-1:0] hop_q, hop_d;
  logic [OW-1:0] back_q, back_d, offc_q, offc_d, back_dec, offf;
  logic [AW-1:0] cand_addr, hole_dist, off_c;
  logic [AW:0]   offf_sum;
  logic          hit;

  always_comb begin
    cand_addr = free_q - AW'(back_q);
    back_dec  = back_q - OW'(1);
    hole_dist = free_q - home_q;
    off_c     = cand_addr - hash_home;
    offf_sum  = {1'b0, off_c} + (AW+1)'(back_q);
    offf      = offc_q + back_q;
    hit       = hop_q[off_q[OW-1:0]] && slot_rdata_q.used && (slot_rdata_q.key == key_q);
  end

  always_comb begin
    state_d    = state_q;
    off_d      = off_q;
    done_d     = 1'b0;
    status_d   = status_q;
    type_d     = type_q;
    key_d      = key_q;
    val_d      = val_q;
    ckey_d     = ckey_q;
    cval_d     = cval_q;
    home_d     = home_q;
    free_d     = free_q;
    ch_d       = ch_q;
    hop_d      = hop_q;
    back_d     = back_q;
    offc_d     = offc_q;
    slot_we    = 1'b0;
    slot_waddr = free_q;
    slot_wdata = '0;
    slot_raddr = home_q + off_q + AW'(1);
    hop_we     = 1'b0;
    hop_waddr  = home_q;
    hop_wdata  = '0;
    hop_raddr  = home_q;
    hash_go    = 1'b0;
    hash_key   = key_q;

    case (state_q)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = off_q;
        hop_we     = 1'b1;
        hop_waddr  = off_q;
        off_d      = off_q + AW'(1);
        if (off_q == AW'(hhtu_pkg::TABLE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          type_d = req_type_i;
          key_d  = req_key_i;
          val_d  = req_value_i;
          if (req_type_i == hhtu_pkg::REQ_LOOKUP || req_type_i == hhtu_pkg::REQ_INSERT ||
              req_type_i == hhtu_pkg::REQ_DELETE) begin
            hash_go  = 1'b1;
            hash_key = req_key_i;
            state_d  = S_HASH;
          end else begin
            done_d   = 1'b1;
            status_d = hhtu_pkg::STS_ABSENT;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          home_d    = hash_home;
          hop_raddr = hash_home;
          state_d   = S_HOPRD;
        end
      end
      S_HOPRD: begin
        hop_d      = hop_rdata_q;
        slot_raddr = home_q;
        off_d      = '0;
        state_d    = S_FIND;
      end
      S_FIND: begin
        if (hit) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          case (type_q)
            hhtu_pkg::REQ_LOOKUP: status_d = hhtu_pkg::STS_OK;
            hhtu_pkg::REQ_DELETE: begin
              status_d        = hhtu_pkg::STS_OK;
              slot_we         = 1'b1;
              slot_waddr      = home_q + off_q;
              slot_wdata      = slot_rdata_q;
              slot_wdata.used = 1'b0;
              hop_we          = 1'b1;
              hop_waddr       = home_q;
              hop_wdata       = hop_q & ~(NBH'(1) << off_q[OW-1:0]);
            end
            default: status_d = hhtu_pkg::STS_DUP;
          endcase
        end else if (off_q == AW'(NBH - 1)) begin
          if (type_q == hhtu_pkg::REQ_INSERT) begin
            slot_raddr = home_q;
            off_d      = '0;
            state_d    = S_PROBE;
          end else begin
            state_d  = S_IDLE;
            done_d   = 1'b1;
            status_d = hhtu_pkg::STS_ABSENT;
          end
        end else begin
          off_d = off_q + AW'(1);
        end
      end
      S_PROBE: begin
        if (!slot_rdata_q.used) begin
          free_d  = home_q + off_q;
          state_d = S_DCHK;
        end else if (off_q == AW'(hhtu_pkg::TABLE_SIZE - 1)) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = hhtu_pkg::STS_FULL;
        end else begin
          off_d = off_q + AW'(1);
        end
      end
      S_DCHK: begin
        if (hole_dist < AW'(NBH)) begin
          hop_raddr = home_q;
          state_d   = S_FWR;
        end else begin
          back_d     = OW'(NBH - 1);
          slot_raddr = free_q - AW'(NBH - 1);
          state_d    = S_CRD;
        end
      end
      S_CRD, S_CHASH: begin
        if (state_q == S_CRD && slot_rdata_q.used) begin
          ckey_d   = slot_rdata_q.key;
          cval_d   = slot_rdata_q.value;
          hash_go  = 1'b1;
          hash_key = slot_rdata_q.key;
          state_d  = S_CHASH;
        end else if (state_q == S_CHASH && !hash_done) begin
          state_d = S_CHASH;
        end else if (state_q == S_CHASH && off_c < AW'(NBH) &&
                     offf_sum < (AW+1)'(NBH)) begin
          ch_d      = hash_home;
          offc_d    = off_c[OW-1:0];
          hop_raddr = hash_home;
          state_d   = S_MV1;
        end else if (back_q == OW'(1)) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = hhtu_pkg::STS_FULL;
        end else begin
          back_d     = back_dec;
          slot_raddr = free_q - AW'(back_dec);
          state_d    = S_CRD;
        end
      end
      S_MV1: begin
        slot_we    = 1'b1;
        slot_waddr = free_q;
        slot_wdata = '{used: 1'b1, key: ckey_q, value: cval_q};
        hop_we     = 1'b1;
        hop_waddr  = ch_q;
        hop_wdata  = (hop_rdata_q & ~(NBH'(1) << offc_q)) | (NBH'(1) << offf);
        state_d    = S_MV2;
      end
      S_MV2: begin
        slot_we    = 1'b1;
        slot_waddr = cand_addr;
        slot_wdata = '{used: 1'b0, key: ckey_q, value: cval_q};
        free_d     = cand_addr;
        state_d    = S_DCHK;
      end
      S_FWR: begin
        slot_we    = 1'b1;
        slot_waddr = free_q;
        slot_wdata = '{used: 1'b1, key: key_q, value: val_q};
        hop_we     = 1'b1;
        hop_waddr  = home_q;
        hop_wdata  = hop_rdata_q | (NBH'(1) << hole_dist[OW-1:0]);
        state_d    = S_IDLE;
        done_d     = 1'b1;
        status_d   = hhtu_pkg::STS_OK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      off_q    <= '0;
      done_q   <= 1'b0;
      status_q <= hhtu_pkg::STS_OK;
    end else begin
      state_q  <= state_d;
      off_q    <= off_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    key_q  <= key_d;
    val_q  <= val_d;
    ckey_q <= ckey_d;
    cval_q <= cval_d;
    home_q <= home_d;
    free_q <= free_d;
    ch_q   <= ch_d;
    hop_q  <= hop_d;
    back_q <= back_d;
    offc_q <= offc_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

  `ASSERT_CLK(a_done_in_idle, done_q |-> state_q == S_IDLE, "result strobe outside idle")
  `ASSERT_CLK(a_accept_resp, start_i && !busy_o |=> busy_o || done_o, "transaction dropped")
  `ASSERT_CLK(a_hash_free, hash_go |-> !hrun_q, "hash unit restarted while running")

endmodule

// ===== test/tb_hopscotch_hash_table_unit.sv =====
module tb_hopscotch_hash_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the block does not define; it must answer "not present".
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned N_RANDOM   = 1430;
  localparam int unsigned SLOT_MASK  = hhtu_pkg::TABLE_SIZE - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = hhtu_pkg::REQ_LOOKUP;
  logic [31:0] req_key_i = '0;
  logic [31:0] req_value_i = '0;
  logic        done_o;
  logic [1:0]  status_o;

  always #10 clk_i = ~clk_i;

  hopscotch_hash_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_type_i (req_type_i),
    .req_key_i  (req_key_i),
    .req_value_i(req_value_i),
    .done_o     (done_o),
    .status_o   (status_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow table: mirrors slot and hop-bitmap contents of the block.
  // Keys and values are only read from slots whose used bit is set.
  // ---------------------------------------------------------------------------
  logic                     shadow_used [hhtu_pkg::TABLE_SIZE];
  logic [31:0]              shadow_key  [hhtu_pkg::TABLE_SIZE];
  logic [31:0]              shadow_val  [hhtu_pkg::TABLE_SIZE];
  logic [hhtu_pkg::NBH-1:0] shadow_hop  [hhtu_pkg::TABLE_SIZE];

  logic [1:0]        status_q[$];   // statuses still owed by the block
  logic [31:0]       key_pool[$];   // keys that were inserted at some point
  bit                failed = 1'b0;

  function automatic int unsigned home_bucket(logic [31:0] k);
    logic [63:0] h;
    h = hhtu_pkg::HASH_INIT ^ {32'd0, k};
    h = h * hhtu_pkg::MM_MUL;
    h = h ^ (h >> hhtu_pkg::MM_SHIFT);
    h = h * hhtu_pkg::MM_MUL;
    h = h ^ (h >> hhtu_pkg::MM_SHIFT);
    return int'(h % hhtu_pkg::TABLE_SIZE);
  endfunction

  function automatic int unsigned wrap_dist(int unsigned from, int unsigned to);
    return (to + hhtu_pkg::TABLE_SIZE - from) & SLOT_MASK;
  endfunction

  // Neighborhood offset holding key k, or -1 when absent.
  function automatic int find_in_hood(logic [31:0] k, int unsigned home);
    int unsigned s;
    for (int i = 0; i < hhtu_pkg::NBH; i++) begin
      s = (home + i) & SLOT_MASK;
      if (shadow_hop[home][i] && shadow_used[s] && shadow_key[s] == k) return i;
    end
    return -1;
  endfunction

  function automatic logic [1:0] table_insert(logic [31:0] k, logic [31:0] v,
                                              int unsigned home);
    int unsigned free_slot;
    int unsigned back;
    int unsigned cand;
    int unsigned ch;
    int unsigned off_c;
    int unsigned off_f;
    bit          found;
    bit          moved;
    free_slot = 0;
    found     = 1'b0;
    if (find_in_hood(k, home) >= 0) return hhtu_pkg::STS_DUP;
    for (int unsigned i = 0; i < hhtu_pkg::TABLE_SIZE; i++) begin
      if (!shadow_used[(home + i) & SLOT_MASK]) begin
        free_slot = (home + i) & SLOT_MASK;
        found     = 1'b1;
        break;
      end
    end
    if (!found) return hhtu_pkg::STS_FULL;
    // hop the hole back toward home; earlier moves stay even on failure
    while (wrap_dist(home, free_slot) >= hhtu_pkg::NBH) begin
      moved = 1'b0;
      for (int unsigned step = 1; step < hhtu_pkg::NBH; step++) begin
        back = hhtu_pkg::NBH - step;
        cand = wrap_dist(back, free_slot);
        if (!shadow_used[cand]) continue;
        ch    = home_bucket(shadow_key[cand]);
        off_c = wrap_dist(ch, cand);
        off_f = off_c + back;
        if (off_c >= hhtu_pkg::NBH || off_f >= hhtu_pkg::NBH) continue;
        shadow_key[free_slot]  = shadow_key[cand];
        shadow_val[free_slot]  = shadow_val[cand];
        shadow_used[free_slot] = 1'b1;
        shadow_used[cand]      = 1'b0;
        shadow_hop[ch][off_c]  = 1'b0;
        shadow_hop[ch][off_f]  = 1'b1;
        free_slot = cand;
        moved     = 1'b1;
        break;
      end
      if (!moved) return hhtu_pkg::STS_FULL;
    end
    shadow_key[free_slot]  = k;
    shadow_val[free_slot]  = v;
    shadow_used[free_slot] = 1'b1;
    shadow_hop[home][wrap_dist(home, free_slot)] = 1'b1;
    return hhtu_pkg::STS_OK;
  endfunction

  // Applies one request to the shadow table and returns its status.
  function automatic logic [1:0] table_apply(logic [1:0] kind, logic [31:0] k,
                                             logic [31:0] v);
    int unsigned home;
    int          off;
    logic [1:0]  sts;
    home = home_bucket(k);
    case (kind)
      hhtu_pkg::REQ_LOOKUP:
        sts = (find_in_hood(k, home) >= 0) ? hhtu_pkg::STS_OK : hhtu_pkg::STS_ABSENT;
      hhtu_pkg::REQ_INSERT: begin
        sts = table_insert(k, v, home);
        if (sts == hhtu_pkg::STS_OK) key_pool.push_back(k);
      end
      hhtu_pkg::REQ_DELETE: begin
        off = find_in_hood(k, home);
        if (off < 0) begin
          sts = hhtu_pkg::STS_ABSENT;
        end else begin
          shadow_used[(home + off) & SLOT_MASK] = 1'b0;
          shadow_hop[home][off] = 1'b0;
          sts = hhtu_pkg::STS_OK;
        end
      end
      default: sts = hhtu_pkg::STS_ABSENT;
    endcase
    return sts;
  endfunction

  // Drive one transaction after an optional idle gap; returns once it is accepted.
  // start_i stays high on exit so back-to-back requests need no toggle.
  task automatic issue(logic [1:0] kind, logic [31:0] k, logic [31:0] v,
                       int unsigned gap, bit known, logic [1:0] known_sts);
    logic [1:0] sts;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    req_type_i  <= kind;
    req_key_i   <= k;
    req_value_i <= v;
    do @(posedge clk_i); while (busy_o);
    sts = table_apply(kind, k, v);
    // hand-written statuses take precedence; the shadow table still updates
    status_q.push_back(known ? known_sts : sts);
  endtask

  // Result checker: the block cannot be stalled, sample on every strobe.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected status, expected none, got %0d", $time, status_o);
        failed = 1'b1;
      end else begin
        if (status_o !== status_q[0]) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, status_q[0], status_o);
          failed = 1'b1;
        end
        void'(status_q.pop_front());
      end
    end
  end

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    logic        known;
    logic [1:0]  sts;
  } stim_row_t;

  stim_row_t directed [20];

  initial begin
    logic [1:0]  kind;
    logic [31:0] k;
    int unsigned pick;
    int unsigned gap;
    bit          burst;
    for (int i = 0; i < hhtu_pkg::TABLE_SIZE; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_hop[i]  = '0;
    end
    // empty table, extremes, duplicate, delete/re-insert, unknown code
    directed = '{
      '{hhtu_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, hhtu_pkg::STS_ABSENT},
      '{hhtu_pkg::REQ_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, hhtu_pkg::STS_ABSENT},
      '{REQ_UNKNOWN,          32'h0000_0000, 32'h0000_0000, 1'b1, hhtu_pkg::STS_ABSENT},
      '{hhtu_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1, hhtu_pkg::STS_DUP},
      '{hhtu_pkg::REQ_LOOKUP, 32'h0000_0000, 32'hffff_ffff, 1'b1, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 1'b1, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, hhtu_pkg::STS_ABSENT},
      '{hhtu_pkg::REQ_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, hhtu_pkg::STS_ABSENT},
      '{hhtu_pkg::REQ_INSERT, 32'h0000_0000, 32'hffff_ffff, 1'b1, hhtu_pkg::STS_OK},
      '{REQ_UNKNOWN,          32'hffff_ffff, 32'hffff_ffff, 1'b1, hhtu_pkg::STS_ABSENT},
      '{hhtu_pkg::REQ_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1'b0, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_INSERT, 32'h0000_0001, 32'h5555_5555, 1'b0, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_INSERT, 32'haaaa_aaaa, 32'haaaa_aaaa, 1'b0, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_DELETE, 32'hffff_ffff, 32'h0000_0000, 1'b0, hhtu_pkg::STS_OK},
      '{hhtu_pkg::REQ_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 1'b0, hhtu_pkg::STS_OK}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i])
      issue(directed[i].kind, directed[i].key, directed[i].value,
            $urandom_range(0, 3), directed[i].known, directed[i].sts);

    // Random part: a fill phase pushes the load past the point where hops
    // and "no room" answers appear, then a drain phase frees slots again.
    burst = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n == 700) begin
        // hold off until the block has answered everything outstanding
        start_i <= 1'b0;
        wait (status_q.size() == 0);
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (n < 1230)
        kind = (pick < 86) ? hhtu_pkg::REQ_INSERT : (pick < 93) ? hhtu_pkg::REQ_LOOKUP :
               (pick < 98) ? hhtu_pkg::REQ_DELETE : REQ_UNKNOWN;
      else
        kind = (pick < 15) ? hhtu_pkg::REQ_INSERT : (pick < 40) ? hhtu_pkg::REQ_LOOKUP :
               (pick < 98) ? hhtu_pkg::REQ_DELETE : REQ_UNKNOWN;
      // known keys drive hits and duplicates, fresh keys drive misses
      if (key_pool.size() > 0 &&
          $urandom_range(0, 99) < ((kind == hhtu_pkg::REQ_INSERT) ? 8 : 75))
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else
        k = $urandom;
      gap = burst ? 0 : $urandom_range(0, 17);
      issue(kind, k, $urandom, gap, 1'b0, hhtu_pkg::STS_OK);
    end
    start_i <= 1'b0;

    wait (status_q.size() == 0);
    repeat (64) @(posedge clk_i);
    if (!failed && status_q.size() == 0) begin
      $display("** hopscotch_hash_table_unit: PASSED **");
    end else begin
      $display("** hopscotch_hash_table_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: generous bound on long probe and displacement chains.
  initial begin
    repeat (50) #1_000_000_000;
    $display("** hopscotch_hash_table_unit: FAILED **");
    $finish;
  end

endmodule
